>>> design/cfp_pkg.sv
// Shared types, constants and CRC helper for the CRC-checked frame parser.
package cfp_pkg;

    // Frame format
    localparam logic [7:0]  SYNC_FIRST   = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND  = 8'h5A;
    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned CRC_BYTES    = 2;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Sizes
    localparam int unsigned DEFAULT_MAX_PAYLOAD = 64;
    localparam int unsigned POS_W               = 7;   // holds header + 64 + crc
    localparam int unsigned COUNT_W             = 7;
    localparam int unsigned INDEX_W             = 6;
    localparam logic [7:0]  VERSION_RESET       = 8'h01;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_READ,
        ST_WAIT
    } cfp_state_t;

    // One byte of CRC-16/MODBUS, bitwise reflected form
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> design/crc_checked_frame_parser.sv
// Top level of the CRC-checked frame parser: sync hunt, header check, payload memory, CRC.
//
// Takes one received byte per rx transaction and finds frames of the form A5 5A, version,
// command, sequence, 16-bit little-endian length, payload, 16-bit little-endian
// CRC-16/MODBUS (computed from the version byte through the payload). A header whose
// version differs from protocol_version or whose length exceeds MAX_PAYLOAD is dropped
// and hunting restarts on the length high byte. Bytes are taken at one per cycle; the
// only stall is at frame end. A CRC mismatch gives one error transaction (frame_ok 0,
// last 1), a good empty frame gives one transaction with byte_valid 0. A good frame
// with payload is read back out of the single-port payload memory one byte at a time (a
// memory read, then a load of the output register once it is free), and rx_ready
// stays low for that burst. The final CRC byte is not taken while the output register
// still holds an untaken transaction. The output register lets the next frame's bytes
// be taken while a result still waits downstream.
module crc_checked_frame_parser
    #(
        parameter int unsigned MAX_PAYLOAD = cfp_pkg::DEFAULT_MAX_PAYLOAD
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        // configuration
        input  logic       cfg_wr_en,
        input  logic [7:0] cfg_wr_data,
        // received bytes
        input  logic       rx_valid,
        output logic       rx_ready,
        input  logic [7:0] rx_byte,
        // result transactions
        output logic       out_valid,
        input  logic       out_ready,
        output logic       frame_ok,
        output logic [7:0] frame_command,
        output logic [7:0] frame_sequence,
        output logic [cfp_pkg::COUNT_W-1:0] payload_count,
        output logic [cfp_pkg::INDEX_W-1:0] payload_index,
        output logic [7:0] payload_byte,
        output logic       byte_valid,
        output logic       last
    );

    import cfp_pkg::*;

    localparam int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned FRAME_LIMIT = HEADER_BYTES + MAX_PAYLOAD + CRC_BYTES;

    // Control state
    cfp_state_t         state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [7:0]         prot_ver_reg;
    logic [ADDR_W-1:0]  emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;

    // Header / CRC payload registers
    logic [7:0]         version_reg, version_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         len_low_reg, len_low_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         crc_low_reg, crc_low_next;

    // Output fields
    logic               ok_reg, ok_next;
    logic [7:0]         ocmd_reg, ocmd_next;
    logic [7:0]         oseq_reg, oseq_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic [INDEX_W-1:0] oidx_reg, oidx_next;
    logic [7:0]         obyte_reg, obyte_next;
    logic               obv_reg, obv_next;
    logic               olast_reg, olast_next;

    // Payload memory
    logic [7:0]         store_mem [MAX_PAYLOAD];
    logic [7:0]         rd_data_reg;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_wr_addr;

    // Decode of the current frame position
    logic               rx_fire;
    logic               out_free;
    logic               in_body;
    logic               is_payload;
    logic               is_crc_low;
    logic               is_final;
    logic               crc_match;
    logic               start_emit;
    logic               emit_load;
    logic               emit_last;
    logic [POS_W-1:0]   hunt_pos;
    logic [15:0]        crc_in;

    assign rx_fire    = rx_valid && rx_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign in_body    = (pos_reg >= POS_W'(HEADER_BYTES)) && (total_reg != '0)
                        && (pos_reg < POS_W'(FRAME_LIMIT));
    assign is_payload = in_body && (pos_reg < total_reg - POS_W'(CRC_BYTES));
    assign is_crc_low = in_body && (pos_reg == total_reg - POS_W'(CRC_BYTES));
    assign is_final   = in_body && !is_payload && !is_crc_low;
    assign crc_match  = ({rx_byte, crc_low_reg} == crc_reg);
    assign start_emit = rx_fire && is_final && crc_match && (len_reg != '0);
    assign emit_last  = (COUNT_W'(emit_idx_reg) + COUNT_W'(1)) == len_reg;
    assign hunt_pos   = (rx_byte == SYNC_FIRST) ? POS_W'(1) : '0;
    assign crc_in     = (pos_reg == POS_W'(2)) ? CRC_INIT : crc_reg;
    assign mem_wr_addr = ADDR_W'(pos_reg - POS_W'(HEADER_BYTES));

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (start_emit) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free) begin
                    state_next = emit_last ? ST_RUN : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        rx_ready  = 1'b0;
        mem_rd_en = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                // final CRC byte may need the output register
                rx_ready = !is_final || !out_valid_reg;
            end
            ST_READ:
            begin
                mem_rd_en = 1'b1;
            end
            ST_WAIT:
            begin
                emit_load = out_free;
            end
            default:
            begin
                rx_ready = 1'b0;
            end
        endcase
    end

    assign mem_wr_en = rx_fire && is_payload;

    // Frame tracking and header capture
    always_comb
    begin
        pos_next     = pos_reg;
        total_next   = total_reg;
        version_next = version_reg;
        cmd_next     = cmd_reg;
        seq_next     = seq_reg;
        len_low_next = len_low_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;

        if (rx_fire) begin
            if ((pos_reg == '0) || ((pos_reg == POS_W'(1)) && (rx_byte != SYNC_SECOND))
                || (pos_reg >= POS_W'(FRAME_LIMIT))) begin
                pos_next   = hunt_pos;
                total_next = '0;
            end
            else begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_W'(HEADER_BYTES)) begin
                    if (pos_reg >= POS_W'(2)) begin
                        crc_next = crc16_update(crc_in, rx_byte);
                    end
                    case (pos_reg)
                        POS_W'(2): version_next = rx_byte;
                        POS_W'(3): cmd_next     = rx_byte;
                        POS_W'(4): seq_next     = rx_byte;
                        POS_W'(5): len_low_next = rx_byte;
                        POS_W'(6):
                        begin
                            // version and length check on the length high byte
                            if ((version_reg != prot_ver_reg) || (rx_byte != 8'h00)
                                || (len_low_reg > 8'(MAX_PAYLOAD))) begin
                                pos_next   = hunt_pos;
                                total_next = '0;
                            end
                            else begin
                                len_next   = COUNT_W'(len_low_reg);
                                total_next = POS_W'(len_low_reg)
                                             + POS_W'(HEADER_BYTES + CRC_BYTES);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (is_payload) begin
                    crc_next = crc16_update(crc_reg, rx_byte);
                end
                else if (is_crc_low) begin
                    crc_low_next = rx_byte;
                end
                else if (is_final) begin
                    pos_next   = '0;
                    total_next = '0;
                end
            end
        end
    end

    // Output register: immediate items at frame end, payload items from memory
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        ocmd_next      = ocmd_reg;
        oseq_next      = oseq_reg;
        ocnt_next      = ocnt_reg;
        oidx_next      = oidx_reg;
        obyte_next     = obyte_reg;
        obv_next       = obv_reg;
        olast_next     = olast_reg;
        emit_idx_next  = emit_idx_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        if (rx_fire && is_final && !start_emit) begin
            // error item or empty good frame
            out_valid_next = 1'b1;
            ok_next        = crc_match;
            ocmd_next      = crc_match ? cmd_reg : 8'h00;
            oseq_next      = crc_match ? seq_reg : 8'h00;
            ocnt_next      = '0;
            oidx_next      = '0;
            obyte_next     = 8'h00;
            obv_next       = 1'b0;
            olast_next     = 1'b1;
        end
        else if (start_emit) begin
            emit_idx_next = '0;
        end
        else if (emit_load) begin
            out_valid_next = 1'b1;
            ok_next        = 1'b1;
            ocmd_next      = cmd_reg;
            oseq_next      = seq_reg;
            ocnt_next      = len_reg;
            oidx_next      = INDEX_W'(emit_idx_reg);
            obyte_next     = rd_data_reg;
            obv_next       = 1'b1;
            olast_next     = emit_last;
            emit_idx_next  = emit_idx_reg + ADDR_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_RUN;
            pos_reg       <= '0;
            total_reg     <= '0;
            prot_ver_reg  <= VERSION_RESET;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                prot_ver_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        version_reg <= version_next;
        cmd_reg     <= cmd_next;
        seq_reg     <= seq_next;
        len_low_reg <= len_low_next;
        len_reg     <= len_next;
        crc_reg     <= crc_next;
        crc_low_reg <= crc_low_next;
        ok_reg      <= ok_next;
        ocmd_reg    <= ocmd_next;
        oseq_reg    <= oseq_next;
        ocnt_reg    <= ocnt_next;
        oidx_reg    <= oidx_next;
        obyte_reg   <= obyte_next;
        obv_reg     <= obv_next;
        olast_reg   <= olast_next;
    end

    // Payload memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en) begin
            store_mem[mem_wr_addr] <= rx_byte;
        end
        if (mem_rd_en) begin
            rd_data_reg <= store_mem[emit_idx_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_ok       = ok_reg;
    assign frame_command  = ocmd_reg;
    assign frame_sequence = oseq_reg;
    assign payload_count  = ocnt_reg;
    assign payload_index  = oidx_reg;
    assign payload_byte   = obyte_reg;
    assign byte_valid     = obv_reg;
    assign last           = olast_reg;

`ifndef SYNTHESIS
    // never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> (!out_valid_reg || out_ready))
        else $error("payload load over a pending output transaction");

    // position stays inside the largest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(FRAME_LIMIT))
        else $error("frame position beyond frame limit");

    // during the payload burst the parser is back to hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> ((pos_reg == '0) && !rx_ready))
        else $error("input taken or frame open during payload burst");

    // payload items carry an index below the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && obv_reg) |-> (COUNT_W'(oidx_reg) < ocnt_reg))
        else $error("payload index not below payload count");

    // a started burst reads memory in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start_emit |=> mem_rd_en)
        else $error("payload burst did not start with a memory read");
`endif

endmodule
